// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge, disabled while the active-low reset is low.
`define ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Check prop on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// File: rtl/ajb_pkg.sv
// ----------------------------------------------------------------------------
// ajb_pkg
// Types and constants of the audio jitter buffer queue.
// ----------------------------------------------------------------------------
package ajb_pkg;

  localparam int QueueDepthDefault = 64;
  localparam int FrameW            = 16;
  localparam int CfgW              = 7;
  localparam int TrimW             = 6;
  localparam int CfgIdxW           = 1;

  localparam logic [CfgW-1:0] StartCountReset = 7'd4;
  localparam logic [CfgW-1:0] ResetCountReset = 7'd48;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_FLUSH = 2'd2
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_COUNT = 1'b0,
    CFG_RESET_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

endpackage

// File: rtl/ajb_ram.sv
// ----------------------------------------------------------------------------
// ajb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ajb_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/audio_jitter_buffer_queue_top.sv
// ----------------------------------------------------------------------------
// audio_jitter_buffer_queue_top
// Bounded FIFO of decoded-frame references with start and trim thresholds.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one word: an action (push,
// pop, flush, or no-op) and a frame reference. Output channel
// (out_valid_o/out_ready_i) returns one status word per input word, in order.
// start_count and reset_count are written through cfg_we_i/cfg_index_i/
// cfg_data_i; the user must write them only while the block is idle, which the block does not enforce.
// Push, flush, no-op and pop of an empty queue show their result in the cycle
// after acceptance, from the output register; a pop that returns a frame
// first passes the S_READ state, set by the registered read of the frame RAM.
// Throughput: one word per cycle for all actions but a returning pop, which
// holds off the next word in S_READ. A trim is a single read-pointer jump.
// The output register lets the next word enter in the cycle the previous
// result is taken; while the receiver stalls, the result holds and no new
// word is accepted.
// Reset clears pointers, fill count, the playing flag and the output valid,
// and reloads the thresholds (start 4, reset 48). The RAM is not cleared:
// entries are read only after they were written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module audio_jitter_buffer_queue_top #(
  parameter int QueueDepth = ajb_pkg::QueueDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ajb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ajb_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  action_i,
  input  logic [ajb_pkg::FrameW-1:0]  frame_ref_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        accepted_o,
  output logic [ajb_pkg::CfgW-1:0]    occupancy_o,
  output logic                        playing_o,
  output logic [ajb_pkg::TrimW-1:0]   trimmed_o,
  output logic                        popped_valid_o,
  output logic [ajb_pkg::FrameW-1:0]  popped_ref_o
);
  import ajb_pkg::*;

  localparam int PtrW  = $clog2(QueueDepth);
  localparam int FillW = $clog2(QueueDepth + 1);
  localparam int CmpW  = (FillW > CfgW) ? FillW : CfgW;
  localparam int SumW  = ((PtrW > TrimW) ? PtrW : TrimW) + 1;

  localparam logic [PtrW-1:0]  PtrLast   = PtrW'(QueueDepth - 1);
  localparam logic [FillW-1:0] FillFull  = FillW'(QueueDepth);
  localparam logic [SumW-1:0]  DepthSum  = SumW'(QueueDepth);
  localparam logic [PtrW:0]    DepthDiff = (PtrW+1)'(QueueDepth);

  state_e            state_q, state_d;
  logic [PtrW-1:0]   rp_q, rp_d, wp_q, wp_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic              playing_q, playing_d;
  logic [CfgW-1:0]   start_q, reset_q;

  logic              out_valid_q, out_valid_d;
  logic              accepted_q, accepted_d;
  logic [CfgW-1:0]   occ_q, occ_d;
  logic              oplay_q, oplay_d;
  logic [TrimW-1:0]  trim_q, trim_d;
  logic              pvalid_q, pvalid_d;
  logic [FrameW-1:0] pref_q, pref_d;

  logic              in_fire, out_load;
  logic              ram_we;
  logic [FrameW-1:0] ram_rdata;

  logic              full;
  logic [FillW-1:0]  fill_push;
  logic [TrimW-1:0]  want, trim;
  logic [SumW-1:0]   rp_sum;
  logic [PtrW-1:0]   rp_trim;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  // Push path: occupancy before trim, then the trim as a pointer jump.
  assign full      = (fill_q == FillFull);
  assign fill_push = full ? fill_q : fill_q + 1'b1;
  assign want      = reset_q[CfgW-1:1];

  always_comb begin
    trim = '0;
    if (playing_q && (CmpW'(fill_push) >= CmpW'(reset_q))) begin
      trim = (CmpW'(want) <= CmpW'(fill_push)) ? want : TrimW'(fill_push);
    end
  end

  assign rp_sum  = SumW'(rp_q) + SumW'(trim);
  assign rp_trim = (rp_sum >= DepthSum) ? PtrW'(rp_sum - DepthSum) : PtrW'(rp_sum);

  always_comb begin
    state_d    = state_q;
    rp_d       = rp_q;
    wp_d       = wp_q;
    fill_d     = fill_q;
    playing_d  = playing_q;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    accepted_d = accepted_q;
    occ_d      = occ_q;
    oplay_d    = oplay_q;
    trim_d     = trim_q;
    pvalid_d   = pvalid_q;
    pref_d     = pref_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_load   = 1'b1;
          accepted_d = 1'b0;
          occ_d      = CfgW'(fill_q);
          oplay_d    = playing_q;
          trim_d     = '0;
          pvalid_d   = 1'b0;
          pref_d     = '0;
          unique case (action_i)
            ACT_PUSH: begin
              ram_we     = !full;
              wp_d       = full ? wp_q : ptr_next(wp_q);
              accepted_d = !full;
              occ_d      = CfgW'(fill_push);
              trim_d     = trim;
              rp_d       = rp_trim;
              fill_d     = fill_push - FillW'(trim);
              if (!playing_q && (CmpW'(fill_push) >= CmpW'(start_q))) begin
                playing_d = 1'b1;
              end
              oplay_d    = playing_d;
            end
            ACT_POP: begin
              if (fill_q != '0) begin
                // Hold the result until the RAM returns the oldest word.
                out_load = 1'b0;
                rp_d     = ptr_next(rp_q);
                fill_d   = fill_q - 1'b1;
                state_d  = S_READ;
              end
            end
            ACT_FLUSH: begin
              rp_d      = '0;
              wp_d      = '0;
              fill_d    = '0;
              playing_d = 1'b0;
              occ_d     = '0;
              oplay_d   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        out_load   = 1'b1;
        accepted_d = 1'b0;
        occ_d      = CfgW'(fill_q);
        oplay_d    = playing_q;
        trim_d     = '0;
        pvalid_d   = 1'b1;
        pref_d     = ram_rdata;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Read address follows the read pointer; a push and a later pop of the
  // same entry never meet at one edge, so no bypass is needed.
  ajb_ram #(
    .Width (FrameW),
    .Depth (QueueDepth)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (frame_ref_i),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rp_q        <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      playing_q   <= 1'b0;
      start_q     <= StartCountReset;
      reset_q     <= ResetCountReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      playing_q   <= playing_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_START_COUNT: start_q <= cfg_data_i;
          CFG_RESET_COUNT: reset_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    accepted_q <= accepted_d;
    occ_q      <= occ_d;
    oplay_q    <= oplay_d;
    trim_q     <= trim_d;
    pvalid_q   <= pvalid_d;
    pref_q     <= pref_d;
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = accepted_q;
  assign occupancy_o    = occ_q;
  assign playing_o      = oplay_q;
  assign trimmed_o      = trim_q;
  assign popped_valid_o = pvalid_q;
  assign popped_ref_o   = pref_q;

  // Pointer distance, used to cross-check the fill count.
  logic [PtrW:0] ptr_dist;
  assign ptr_dist = (wp_q >= rp_q) ? (PtrW+1)'(wp_q - rp_q)
                                   : (PtrW+1)'(wp_q) + DepthDiff - (PtrW+1)'(rp_q);

  `ASSERT_ALWAYS(a_fill_bound, clk_i, !rst_ni || (fill_q <= FillFull))
  `ASSERT_RST(a_ptr_fill, clk_i, rst_ni,
              (fill_q == FillFull) ? (ptr_dist == '0) : (FillW'(ptr_dist) == fill_q))
  `ASSERT_RST(a_read_slot_free, clk_i, rst_ni,
              (state_q == S_READ) |-> !out_valid_q)
  `ASSERT_RST(a_flush_clears, clk_i, rst_ni,
              (in_fire && action_i == ACT_FLUSH) |=> (fill_q == '0 && !playing_q))

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the audio jitter buffer queue: directed rows, then
// random push/pop/flush/no-op traffic over several threshold settings; each status
// word is checked against a table entry or a behavioral model of the queue.
// ----------------------------------------------------------------------------
module tb;
  import ajb_pkg::*;

  localparam int QueueDepth = QueueDepthDefault;
  localparam logic [1:0] ActNop = 2'd3;
  localparam int NumPhases  = 8;
  localparam int PhaseItems = 191;
  localparam int HoldCycles = 60;
  localparam int CycleLimit = 400000;
  localparam int DirRows    = 27;

  typedef struct packed {
    logic        accepted;
    logic [6:0]  occupancy;
    logic        playing;
    logic [5:0]  trimmed;
    logic        popped_valid;
    logic [15:0] popped_ref;
  } status_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    cfg_idx_e    cfg_idx;
    logic [6:0]  cfg_val;
    logic [1:0]  act;
    logic [15:0] fref;
    logic        typed;
    status_t     want;
  } dir_row_t;

  localparam status_t ZeroStatus = '0;

  localparam dir_row_t DirTable [DirRows] = '{
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ACT_POP,   16'h0000, 1'b1, ZeroStatus},
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ACT_PUSH,  16'h0000, 1'b1,
      '{1'b1, 7'd1, 1'b0, 6'd0, 1'b0, 16'h0000}},
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ACT_PUSH,  16'hFFFF, 1'b1,
      '{1'b1, 7'd2, 1'b0, 6'd0, 1'b0, 16'h0000}},
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ACT_PUSH,  16'hA5A5, 1'b0, ZeroStatus},
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ACT_PUSH,  16'h5A5A, 1'b1,
      '{1'b1, 7'd4, 1'b1, 6'd0, 1'b0, 16'h0000}},
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ACT_POP,   16'h0000, 1'b1,
      '{1'b0, 7'd3, 1'b1, 6'd0, 1'b1, 16'h0000}},
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ACT_POP,   16'h0000, 1'b1,
      '{1'b0, 7'd2, 1'b1, 6'd0, 1'b1, 16'hFFFF}},
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ActNop,    16'h1234, 1'b1,
      '{1'b0, 7'd2, 1'b1, 6'd0, 1'b0, 16'h0000}},
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ACT_FLUSH, 16'h0000, 1'b1, ZeroStatus},
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ACT_POP,   16'h0000, 1'b1, ZeroStatus},
    '{ROW_CFG,  CFG_START_COUNT, 7'd0,  ACT_PUSH,  16'h0000, 1'b0, ZeroStatus},
    '{ROW_CFG,  CFG_RESET_COUNT, 7'd4,  ACT_PUSH,  16'h0000, 1'b0, ZeroStatus},
    // start count of zero: the first push starts playback
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ACT_PUSH,  16'h0001, 1'b1,
      '{1'b1, 7'd1, 1'b1, 6'd0, 1'b0, 16'h0000}},
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ACT_PUSH,  16'h0002, 1'b0, ZeroStatus},
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ACT_PUSH,  16'h0003, 1'b0, ZeroStatus},
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ACT_PUSH,  16'h0004, 1'b1,
      '{1'b1, 7'd4, 1'b1, 6'd2, 1'b0, 16'h0000}},
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ACT_POP,   16'h0000, 1'b0, ZeroStatus},
    // reset count of one asks for a trim of zero frames
    '{ROW_CFG,  CFG_RESET_COUNT, 7'd1,  ACT_PUSH,  16'h0000, 1'b0, ZeroStatus},
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ACT_PUSH,  16'h8000, 1'b0, ZeroStatus},
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ACT_PUSH,  16'h7FFF, 1'b0, ZeroStatus},
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ACT_FLUSH, 16'h0000, 1'b1, ZeroStatus},
    '{ROW_CFG,  CFG_START_COUNT, 7'd64, ACT_PUSH,  16'h0000, 1'b0, ZeroStatus},
    '{ROW_CFG,  CFG_RESET_COUNT, 7'd0,  ACT_PUSH,  16'h0000, 1'b0, ZeroStatus},
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ACT_PUSH,  16'h1111, 1'b1,
      '{1'b1, 7'd1, 1'b0, 6'd0, 1'b0, 16'h0000}},
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ActNop,    16'hFFFF, 1'b0, ZeroStatus},
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ACT_POP,   16'h0000, 1'b0, ZeroStatus},
    '{ROW_ITEM, CFG_START_COUNT, 7'd0,  ACT_POP,   16'h0000, 1'b1, ZeroStatus}
  };

  localparam logic [6:0] PhaseStart [NumPhases] =
    '{7'd4, 7'd0, 7'd64, 7'd63, 7'd1, 7'd16, 7'd64, 7'd0};
  localparam logic [6:0] PhaseReset [NumPhases] =
    '{7'd48, 7'd0, 7'd64, 7'd1, 7'd6, 7'd63, 7'd0, 7'd32};

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          action_i;
  logic [FrameW-1:0]   frame_ref_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                accepted_o;
  logic [CfgW-1:0]     occupancy_o;
  logic                playing_o;
  logic [TrimW-1:0]    trimmed_o;
  logic                popped_valid_o;
  logic [FrameW-1:0]   popped_ref_o;

  audio_jitter_buffer_queue_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .frame_ref_i   (frame_ref_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .accepted_o    (accepted_o),
    .occupancy_o   (occupancy_o),
    .playing_o     (playing_o),
    .trimmed_o     (trimmed_o),
    .popped_valid_o(popped_valid_o),
    .popped_ref_o  (popped_ref_o)
  );

  // model of the queue
  logic [15:0] frame_mem [QueueDepth];
  int          rd_idx;
  int          wr_idx;
  int          frames_held;
  logic        play_flag;
  int          start_thr;
  int          reset_thr;

  status_t     pending_status_q [$];
  status_t     due_status;
  int          mismatch_count;
  int          cycle_count;
  bit          idle_on;
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic status_t predict_status(logic [1:0] act, logic [15:0] fref);
    status_t s;
    int      trim_n;
    s = '0;
    case (act)
      ACT_PUSH: begin
        if (frames_held < QueueDepth) begin
          frame_mem[wr_idx] = fref;
          wr_idx = (wr_idx + 1) % QueueDepth;
          frames_held++;
          s.accepted = 1'b1;
        end
        s.occupancy = 7'(frames_held);
        if (!play_flag) begin
          if (frames_held >= start_thr) play_flag = 1'b1;
        end else if (frames_held >= reset_thr) begin
          // drop the oldest half of the reset count
          trim_n = reset_thr / 2;
          if (trim_n > frames_held) trim_n = frames_held;
          rd_idx = (rd_idx + trim_n) % QueueDepth;
          frames_held -= trim_n;
          s.trimmed = 6'(trim_n);
        end
      end
      ACT_POP: begin
        if (frames_held > 0) begin
          s.popped_valid = 1'b1;
          s.popped_ref = frame_mem[rd_idx];
          rd_idx = (rd_idx + 1) % QueueDepth;
          frames_held--;
        end
      end
      ACT_FLUSH: begin
        rd_idx = 0;
        wr_idx = 0;
        frames_held = 0;
        play_flag = 1'b0;
      end
      default: ;
    endcase
    if (act != ACT_PUSH) s.occupancy = 7'(frames_held);
    s.playing = play_flag;
    return s;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_status_q.size() == 0) begin
        report_mismatch("status word with none pending");
      end else begin
        due_status = pending_status_q[0];
        pending_status_q.delete(0);
        check_field("accepted", 32'(accepted_o), 32'(due_status.accepted));
        check_field("occupancy", 32'(occupancy_o), 32'(due_status.occupancy));
        check_field("playing", 32'(playing_o), 32'(due_status.playing));
        check_field("trimmed", 32'(trimmed_o), 32'(due_status.trimmed));
        check_field("popped_valid", 32'(popped_valid_o), 32'(due_status.popped_valid));
        check_field("popped_ref", 32'(popped_ref_o), 32'(due_status.popped_ref));
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(logic [1:0] act, logic [15:0] fref, logic typed,
                           status_t want);
    status_t pred;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    frame_ref_i <= fref;
    do @(posedge clk_i); while (!in_ready_o);
    pred = predict_status(act, fref);
    pending_status_q = {pending_status_q, (typed ? want : pred)};
    @(negedge clk_i);
  endtask

  // hold until every status word is back, then let the block settle
  task automatic wait_idle();
    while (pending_status_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_threshold(cfg_idx_e idx, logic [6:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    if (idx == CFG_START_COUNT) start_thr = int'(val);
    else reset_thr = int'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    logic [1:0]  act;
    logic [15:0] fref;
    logic [6:0]  st_val;
    logic [6:0]  rs_val;
    int          push_pct;
    int          r;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_START_COUNT;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    action_i    = ACT_PUSH;
    frame_ref_i = '0;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    rd_idx = 0;
    wr_idx = 0;
    frames_held = 0;
    play_flag = 1'b0;
    start_thr = int'(StartCountReset);
    reset_thr = int'(ResetCountReset);
    push_pct = 50;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DirTable[i]) begin
      if (DirTable[i].kind == ROW_CFG) begin
        in_valid_i <= 1'b0;
        wait_idle();
        write_threshold(DirTable[i].cfg_idx, DirTable[i].cfg_val);
      end else begin
        send_word(DirTable[i].act, DirTable[i].fref, DirTable[i].typed, DirTable[i].want);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      in_valid_i <= 1'b0;
      wait_idle();
      st_val = PhaseStart[ph];
      rs_val = PhaseReset[ph];
      if (ph == NumPhases - 1) begin
        st_val = 7'($urandom_range(0, 64));
        rs_val = 7'($urandom_range(0, 64));
      end
      write_threshold(CFG_START_COUNT, st_val);
      write_threshold(CFG_RESET_COUNT, rs_val);
      // no idling in the closing phase
      idle_on = (ph != NumPhases - 1);
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 32 == 0) begin
          case ($urandom_range(0, 4))
            0: push_pct = 25;
            1: push_pct = 50;
            2: push_pct = 75;
            3: push_pct = 90;
            default: push_pct = 100;
          endcase
        end
        if (ph == 1 && n == 20) hold_req = 1'b1;
        if (ph == 3 && n == PhaseItems / 2) begin
          in_valid_i <= 1'b0;
          wait_idle();
        end
        r = $urandom_range(0, 99);
        if (r == 0) act = ACT_FLUSH;
        else if (r == 1) act = ActNop;
        else if ($urandom_range(1, 100) <= push_pct) act = ACT_PUSH;
        else act = ACT_POP;
        if ($urandom_range(0, 7) == 0) fref = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else fref = 16'($urandom);
        send_word(act, fref, 1'b0, ZeroStatus);
      end
    end

    in_valid_i <= 1'b0;
    wait_idle();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
